[hw/rtl/itw_pkg.sv]
// ----------------------------------------------------------------------------
// itw_pkg
// Shared widths, codes, control structs and helpers of the isometric tile walk.
// ----------------------------------------------------------------------------
`default_nettype none

package itw_pkg;

   localparam int COORD_BITS = 17;
   localparam int CALC_BITS  = COORD_BITS + 2;
   localparam int PIX_BITS   = 18;
   localparam int DIV_BITS   = 15;
   localparam int REM_BITS   = 9;
   localparam int PROD_BITS  = COORD_BITS + REM_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 15;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_TILE_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_VIEW_LEFT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_VIEW_TOP    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_VIEW_RIGHT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_VIEW_BOTTOM = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAP_COLUMNS = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAP_ROWS    = 3'd6;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CALC_BITS-1:0]  calc_type;
   typedef logic signed [PIX_BITS-1:0]   pix_type;

   localparam calc_type COORD_LIM = calc_type'((1 << (COORD_BITS - 1)) - 1);

   typedef struct packed {
      logic start_load;
      logic div_go;
      logic div_y;
      logic take_x;
      logic take_y;
      logic init;
      logic reply;
      logic end_row;
      logic second_miss;
      logic calc_lo;
      logic move;
      logic first_miss;
      logic stop;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic walking;
      logic div_done;
      logic y_end;
      logic x_end;
      logic second;
      logic in_map;
      logic lo_bad;
   } stat_type;

   function automatic coord_type sat_coord(input calc_type v);
      coord_type r;
      if (v > COORD_LIM) begin
         r = coord_type'(COORD_LIM);
      end else if (v < -COORD_LIM) begin
         r = coord_type'(-COORD_LIM);
      end else begin
         r = coord_type'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/itw_req_if.sv]
// ----------------------------------------------------------------------------
// itw_req_if
// Request channel: frame start or cell data reply.
// ----------------------------------------------------------------------------
`default_nettype none

interface itw_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [14:0] scroll_x;
   logic [14:0] scroll_y;
   logic [15:0] tile_id;
   logic [15:0] cell_flag_bits;
   logic        holds_object;
   logic        object_self_draws;
   logic        path_cell;

   modport source (output valid, kind, scroll_x, scroll_y, tile_id, cell_flag_bits,
                   holds_object, object_self_draws, path_cell, input ready);
   modport sink   (input valid, kind, scroll_x, scroll_y, tile_id, cell_flag_bits,
                   holds_object, object_self_draws, path_cell, output ready);
endinterface

`default_nettype wire

[hw/rtl/itw_rsp_if.sv]
// ----------------------------------------------------------------------------
// itw_rsp_if
// Response channel: draw command plus next cell request.
// ----------------------------------------------------------------------------
`default_nettype none

interface itw_rsp_if;
   logic               valid;
   logic               ready;
   logic               draw_enable;
   logic [15:0]        draw_tile;
   logic signed [15:0] draw_px;
   logic signed [15:0] draw_py;
   logic               overlay_enable;
   logic [7:0]         want_column;
   logic [7:0]         want_row;
   logic               walk_done;

   modport source (output valid, draw_enable, draw_tile, draw_px, draw_py, overlay_enable,
                   want_column, want_row, walk_done, input ready);
   modport sink   (input valid, draw_enable, draw_tile, draw_px, draw_py, overlay_enable,
                   want_column, want_row, walk_done, output ready);
endinterface

`default_nettype wire

[hw/rtl/isometric_tile_walk.sv]
// ----------------------------------------------------------------------------
// isometric_tile_walk
// Tile-walk controller for a 2:1 isometric diamond map.
// ----------------------------------------------------------------------------
// A start item divides the scroll position by the tile size in a bit-serial
// divider (two divisions) and then seeks the first in-map cell before it
// loads the response register. A cell reply is accepted, passes at least once
// through the seek check (a diamond-row span jump goes on through the
// multiplier, and more checks follow when off-map cells or row ends are
// skipped) and then loads the response register. Every item gives one
// response; the next item is accepted while an earlier response still waits.
`default_nettype none

module isometric_tile_walk (
   input  wire logic                               clock,
   input  wire logic                               reset,
   itw_req_if.sink                                 req_chan,
   itw_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [itw_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [itw_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   itw_pkg::cmd_type  cmd;
   itw_pkg::stat_type stat;

   itw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_kind   (req_chan.kind),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   itw_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .scroll_x          (req_chan.scroll_x),
      .scroll_y          (req_chan.scroll_y),
      .tile_id           (req_chan.tile_id),
      .cell_flag_bits    (req_chan.cell_flag_bits),
      .holds_object      (req_chan.holds_object),
      .object_self_draws (req_chan.object_self_draws),
      .path_cell         (req_chan.path_cell),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .draw_enable       (rsp_chan.draw_enable),
      .draw_tile         (rsp_chan.draw_tile),
      .draw_px           (rsp_chan.draw_px),
      .draw_py           (rsp_chan.draw_py),
      .overlay_enable    (rsp_chan.overlay_enable),
      .want_column       (rsp_chan.want_column),
      .want_row          (rsp_chan.want_row),
      .walk_done         (rsp_chan.walk_done)
   );

   // response register is never overwritten while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("response overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_chan.valid)
      else $error("emitted response not presented");

   // one item in flight: no new item the cycle after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second item accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |=> !stat.div_done)
      else $error("divider finished too early");

endmodule

`default_nettype wire

[hw/rtl/itw_div.sv]
// ----------------------------------------------------------------------------
// itw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itw_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [itw_pkg::DIV_BITS-1:0]  dividend,
   input  wire logic [itw_pkg::REM_BITS-1:0]  divisor,
   output logic      [itw_pkg::DIV_BITS-1:0]  quotient,
   output logic      [itw_pkg::REM_BITS-1:0]  remainder,
   output logic                               done
);
   localparam int CNT_BITS = $clog2(itw_pkg::DIV_BITS + 1);

   logic [itw_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [itw_pkg::REM_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [itw_pkg::REM_BITS:0]   trial;
   logic                         ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[itw_pkg::DIV_BITS-1]};
      ge      = trial >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(itw_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[itw_pkg::DIV_BITS-2:0], ge};
         rem_in = ge ? itw_pkg::REM_BITS'(trial - {1'b0, divisor})
                     : trial[itw_pkg::REM_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

`default_nettype wire

[hw/rtl/itw_dp.sv]
// ----------------------------------------------------------------------------
// itw_dp
// Walk datapath: config registers, start division and correction, walk
// position, cell stepping and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module itw_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire itw_pkg::cmd_type                   cmd,
   output itw_pkg::stat_type                       stat,
   input  wire logic [14:0]                        scroll_x,
   input  wire logic [14:0]                        scroll_y,
   input  wire logic [15:0]                        tile_id,
   input  wire logic [15:0]                        cell_flag_bits,
   input  wire logic                               holds_object,
   input  wire logic                               object_self_draws,
   input  wire logic                               path_cell,
   input  wire logic                               csr_we,
   input  wire logic [itw_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [itw_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                    draw_enable,
   output logic [15:0]                             draw_tile,
   output logic signed [15:0]                      draw_px,
   output logic signed [15:0]                      draw_py,
   output logic                                    overlay_enable,
   output logic [7:0]                              want_column,
   output logic [7:0]                              want_row,
   output logic                                    walk_done
);
   localparam int W12 = 12;
   localparam itw_pkg::calc_type CALC_ONE   = itw_pkg::calc_type'(1);
   localparam itw_pkg::calc_type CALC_THREE = itw_pkg::calc_type'(3);

   // config
   logic [7:0]  th_cfg_ff, mc_ff, mr_ff;
   logic [14:0] vl_ff, vt_ff, vr_ff, vb_ff;

   // start operands and division results
   logic [14:0]                  sx_ff, sy_ff;
   logic [itw_pkg::DIV_BITS-1:0] q_ff, q_in;
   logic [itw_pkg::REM_BITS-1:0] xr_ff, xr_in;
   logic signed [15:0]           r_ff, r_in;
   logic signed [9:0]            yr_ff, yr_in;

   // walk state
   itw_pkg::coord_type cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   itw_pkg::coord_type line_col_ff, line_col_in, line_row_ff, line_row_in;
   itw_pkg::pix_type   pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [8:0]         rem_x_ff, rem_x_in;
   logic               second_ff, second_in;
   logic               walking_ff, walking_in;
   itw_pkg::calc_type  lo_ff, lo_in, hi_ff, hi_in;

   // pending draw of the last reply
   logic               pen_en_ff, pen_en_in, pen_ov_ff, pen_ov_in;
   logic [15:0]        pen_tile_ff, pen_tile_in;
   logic signed [15:0] pen_px_ff, pen_px_in, pen_py_ff, pen_py_in;

   // response register
   logic               o_en_ff, o_ov_ff, o_done_ff;
   logic [15:0]        o_tile_ff;
   logic signed [15:0] o_px_ff, o_py_ff;
   logic [7:0]         o_col_ff, o_row_ff;

   // derived values
   logic [8:0]                       th, tw;
   logic [7:0]                       halfh;
   itw_pkg::pix_type                 xlim, ylim, row_x;
   itw_pkg::calc_type                cc, cr, wc, hc;
   logic                             in_map;
   logic signed [15:0]               ys;
   logic [itw_pkg::DIV_BITS-1:0]     ymag;
   logic [itw_pkg::DIV_BITS-1:0]     div_dividend, div_q;
   logic [itw_pkg::REM_BITS-1:0]     div_divisor, div_r;
   logic                             div_done;
   logic [itw_pkg::PROD_BITS-1:0]    prod;
   logic signed [itw_pkg::PROD_BITS:0] prod_w, diff_w;
   logic                             lo_bad;

   assign th    = (th_cfg_ff == 8'd0) ? 9'd1 : {1'b0, th_cfg_ff};
   assign tw    = {th[7:0], 1'b0};
   assign halfh = 8'((th + 9'd1) >> 1);
   assign xlim  = $signed(itw_pkg::PIX_BITS'(vr_ff)) + $signed(itw_pkg::PIX_BITS'({th, 2'b00}));
   assign ylim  = $signed(itw_pkg::PIX_BITS'(vb_ff)) + $signed(itw_pkg::PIX_BITS'({th, 1'b0}));
   assign row_x = $signed(itw_pkg::PIX_BITS'(vl_ff)) - $signed(itw_pkg::PIX_BITS'({th, 2'b00}))
                  - $signed(itw_pkg::PIX_BITS'(rem_x_ff));
   assign cc    = itw_pkg::calc_type'(cur_col_ff);
   assign cr    = itw_pkg::calc_type'(cur_row_ff);
   assign wc    = itw_pkg::calc_type'(mc_ff);
   assign hc    = itw_pkg::calc_type'(mr_ff);
   assign in_map = (cc >= 0) && (cc < wc) && (cr >= 0) && (cr < hc);

   assign ys   = $signed({1'b0, sy_ff}) - $signed({8'd0, halfh});
   assign ymag = ys[15] ? itw_pkg::DIV_BITS'(-ys) : ys[14:0];
   assign div_dividend = cmd.div_y ? ymag : sx_ff;
   assign div_divisor  = cmd.div_y ? th : tw;

   itw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done)
   );

   assign prod   = itw_pkg::PROD_BITS'(lo_ff[itw_pkg::COORD_BITS-1:0] * tw);
   assign prod_w = $signed({1'b0, prod});
   assign diff_w = (itw_pkg::PROD_BITS+1)'(xlim - pix_x_ff);
   assign lo_bad = (lo_ff > hi_ff) || (prod_w >= diff_w);

   assign stat.walking  = walking_ff;
   assign stat.div_done = div_done;
   assign stat.y_end    = pix_y_ff >= ylim;
   assign stat.x_end    = pix_x_ff >= xlim;
   assign stat.second   = second_ff;
   assign stat.in_map   = in_map;
   assign stat.lo_bad   = lo_bad;

   always_comb begin
      logic signed [W12-1:0] xs, yv, t12, h12;
      logic signed [W12-1:0] xn, yn;
      itw_pkg::calc_type     dc, dr, c0, r0, a, b, lo, hi, nc;
      logic                  blk, hit;
      itw_pkg::pix_type      dx, dy;

      q_in        = q_ff;
      xr_in       = xr_ff;
      r_in        = r_ff;
      yr_in       = yr_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      line_col_in = line_col_ff;
      line_row_in = line_row_ff;
      pix_x_in    = pix_x_ff;
      pix_y_in    = pix_y_ff;
      rem_x_in    = rem_x_ff;
      second_in   = second_ff;
      walking_in  = walking_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pen_en_in   = pen_en_ff;
      pen_ov_in   = pen_ov_ff;
      pen_tile_in = pen_tile_ff;
      pen_px_in   = pen_px_ff;
      pen_py_in   = pen_py_ff;

      // start cell correction by diamond quarter
      xs  = W12'(xr_ff);
      yv  = W12'(yr_ff);
      t12 = W12'(th);
      h12 = W12'(halfh);
      dc  = '0;
      dr  = '0;
      xn  = xs;
      yn  = yv;
      case ({xs >= t12, yv > h12})
         2'b00: begin
            if (xs < t12 - 2 * yv) begin
               dc = -CALC_ONE; xn = xs + t12; yn = yv + h12;
            end
         end
         2'b10: begin
            if (xs >= t12 + 2 * yv) begin
               dr = -CALC_ONE; xn = xs - t12; yn = yv + h12;
            end
         end
         2'b01: begin
            if (xs < t12 + 2 * (yv - t12)) begin
               dr = CALC_ONE; xn = xs + t12; yn = yv - h12;
            end
         end
         default: begin
            if (xs >= t12 + 2 * (t12 - yv)) begin
               dc = CALC_ONE; xn = xs - t12; yn = yv - h12;
            end
         end
      endcase
      c0 = itw_pkg::calc_type'(r_ff) + itw_pkg::calc_type'(q_ff) - CALC_THREE + dc;
      r0 = itw_pkg::calc_type'(r_ff) - itw_pkg::calc_type'(q_ff) + dr;

      // diamond row span
      a  = -cc - CALC_ONE;
      b  = cr - hc + CALC_ONE;
      lo = '0;
      if (a > lo) lo = a;
      if (b > lo) lo = b;
      hi = wc - CALC_ONE - cc;
      if (cr < hi) hi = cr;

      // draw decision for a reply
      blk = (|cell_flag_bits[1:0]) && cell_flag_bits[3] && holds_object;
      hit = walking_ff && (tile_id != 16'd0);
      dx  = pix_x_ff + (second_ff ? itw_pkg::pix_type'(th) : '0);
      dy  = pix_y_ff + (second_ff ? itw_pkg::pix_type'(halfh) : '0);
      nc  = itw_pkg::calc_type'(itw_pkg::sat_coord(cc + CALC_ONE));

      if (cmd.start_load) begin
         pen_en_in   = 1'b0;
         pen_ov_in   = 1'b0;
         pen_tile_in = '0;
         pen_px_in   = '0;
         pen_py_in   = '0;
      end
      if (cmd.take_x) begin
         q_in  = div_q;
         xr_in = div_r;
      end
      if (cmd.take_y) begin
         r_in  = ys[15] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
         yr_in = ys[15] ? -$signed(10'(div_r)) : $signed(10'(div_r));
      end
      if (cmd.init) begin
         rem_x_in    = xn[8:0];
         cur_col_in  = itw_pkg::sat_coord(c0);
         line_col_in = itw_pkg::sat_coord(c0);
         cur_row_in  = itw_pkg::sat_coord(r0);
         line_row_in = itw_pkg::sat_coord(r0);
         pix_x_in    = $signed(itw_pkg::PIX_BITS'(vl_ff))
                       - $signed(itw_pkg::PIX_BITS'({th, 2'b00}))
                       - itw_pkg::PIX_BITS'(xn);
         pix_y_in    = $signed(itw_pkg::PIX_BITS'(vt_ff))
                       - $signed(itw_pkg::PIX_BITS'({th, 1'b0}))
                       - itw_pkg::PIX_BITS'(yn);
         second_in   = 1'b0;
         walking_in  = 1'b1;
      end
      if (cmd.reply) begin
         pen_en_in   = hit && !(blk && object_self_draws);
         pen_ov_in   = hit && !blk && path_cell;
         pen_tile_in = pen_en_in ? tile_id : '0;
         pen_px_in   = pen_en_in ? dx[15:0] : '0;
         pen_py_in   = pen_en_in ? dy[15:0] : '0;
         if (walking_ff) begin
            if (!second_ff) begin
               if (nc == wc) begin
                  pix_y_in    = pix_y_ff + itw_pkg::pix_type'(th);
                  line_col_in = itw_pkg::sat_coord(itw_pkg::calc_type'(line_col_ff) + CALC_ONE);
                  line_row_in = itw_pkg::sat_coord(itw_pkg::calc_type'(line_row_ff) + CALC_ONE);
                  cur_col_in  = line_col_in;
                  cur_row_in  = line_row_in;
                  pix_x_in    = row_x;
                  second_in   = 1'b0;
               end else begin
                  cur_col_in = itw_pkg::coord_type'(nc);
                  second_in  = 1'b1;
               end
            end else begin
               cur_row_in = itw_pkg::sat_coord(cr - CALC_ONE);
               second_in  = 1'b0;
               pix_x_in   = pix_x_ff + itw_pkg::pix_type'(tw);
            end
         end
      end
      if (cmd.end_row) begin
         pix_y_in    = pix_y_ff + itw_pkg::pix_type'(th);
         line_col_in = itw_pkg::sat_coord(itw_pkg::calc_type'(line_col_ff) + CALC_ONE);
         line_row_in = itw_pkg::sat_coord(itw_pkg::calc_type'(line_row_ff) + CALC_ONE);
         cur_col_in  = line_col_in;
         cur_row_in  = line_row_in;
         pix_x_in    = row_x;
         second_in   = 1'b0;
      end
      if (cmd.second_miss) begin
         cur_row_in = itw_pkg::sat_coord(cr - CALC_ONE);
         second_in  = 1'b0;
         pix_x_in   = pix_x_ff + itw_pkg::pix_type'(tw);
      end
      if (cmd.calc_lo) begin
         lo_in = lo;
         hi_in = hi;
      end
      if (cmd.move) begin
         cur_col_in = itw_pkg::sat_coord(cc + lo_ff);
         cur_row_in = itw_pkg::sat_coord(cr - lo_ff);
         pix_x_in   = pix_x_ff + itw_pkg::pix_type'(prod);
      end
      if (cmd.first_miss) begin
         cur_col_in = itw_pkg::sat_coord(cc + CALC_ONE);
         second_in  = 1'b1;
      end
      if (cmd.stop) begin
         walking_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         sx_ff <= scroll_x;
         sy_ff <= scroll_y;
      end
      q_ff        <= q_in;
      xr_ff       <= xr_in;
      r_ff        <= r_in;
      yr_ff       <= yr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      pen_en_ff   <= pen_en_in;
      pen_ov_ff   <= pen_ov_in;
      pen_tile_ff <= pen_tile_in;
      pen_px_ff   <= pen_px_in;
      pen_py_ff   <= pen_py_in;
      if (cmd.emit) begin
         o_en_ff   <= pen_en_ff;
         o_ov_ff   <= pen_ov_ff;
         o_tile_ff <= pen_tile_ff;
         o_px_ff   <= pen_px_ff;
         o_py_ff   <= pen_py_ff;
         o_col_ff  <= walking_ff ? cur_col_ff[7:0] : 8'd0;
         o_row_ff  <= walking_ff ? cur_row_ff[7:0] : 8'd0;
         o_done_ff <= !walking_ff;
      end
      if (reset) begin
         th_cfg_ff   <= 8'd16;
         vl_ff       <= 15'd0;
         vt_ff       <= 15'd0;
         vr_ff       <= 15'd640;
         vb_ff       <= 15'd480;
         mc_ff       <= 8'd128;
         mr_ff       <= 8'd128;
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         line_col_ff <= '0;
         line_row_ff <= '0;
         pix_x_ff    <= '0;
         pix_y_ff    <= '0;
         rem_x_ff    <= '0;
         second_ff   <= 1'b0;
         walking_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               itw_pkg::REG_TILE_HEIGHT: th_cfg_ff <= csr_wdata[7:0];
               itw_pkg::REG_VIEW_LEFT:   vl_ff     <= csr_wdata;
               itw_pkg::REG_VIEW_TOP:    vt_ff     <= csr_wdata;
               itw_pkg::REG_VIEW_RIGHT:  vr_ff     <= csr_wdata;
               itw_pkg::REG_VIEW_BOTTOM: vb_ff     <= csr_wdata;
               itw_pkg::REG_MAP_COLUMNS: mc_ff     <= csr_wdata[7:0];
               itw_pkg::REG_MAP_ROWS:    mr_ff     <= csr_wdata[7:0];
               default: ;
            endcase
         end
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         line_col_ff <= line_col_in;
         line_row_ff <= line_row_in;
         pix_x_ff    <= pix_x_in;
         pix_y_ff    <= pix_y_in;
         rem_x_ff    <= rem_x_in;
         second_ff   <= second_in;
         walking_ff  <= walking_in;
      end
   end

   assign draw_enable    = o_en_ff;
   assign draw_tile      = o_tile_ff;
   assign draw_px        = o_px_ff;
   assign draw_py        = o_py_ff;
   assign overlay_enable = o_ov_ff;
   assign want_column    = o_col_ff;
   assign want_row       = o_row_ff;
   assign walk_done      = o_done_ff;
endmodule

`default_nettype wire

[hw/rtl/itw_ctrl.sv]
// ----------------------------------------------------------------------------
// itw_ctrl
// Walk sequencer: start division, cell seek loop and response handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module itw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic               in_kind,
   output logic                    in_ready,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output itw_pkg::cmd_type        cmd,
   input  wire itw_pkg::stat_type  stat
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_XGO   = 4'd1;
   localparam logic [3:0] ST_XWAIT = 4'd2;
   localparam logic [3:0] ST_YGO   = 4'd3;
   localparam logic [3:0] ST_YWAIT = 4'd4;
   localparam logic [3:0] ST_CORR  = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_LO    = 4'd7;
   localparam logic [3:0] ST_MUL   = 4'd8;
   localparam logic [3:0] ST_FIRST = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       ov_ff, ov_in;
   logic       out_free;

   assign out_free = !ov_ff || out_ready;
   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_kind == itw_pkg::KIND_START) begin
                  cmd.start_load = 1'b1;
                  state_in       = ST_XGO;
               end else begin
                  cmd.reply = 1'b1;
                  state_in  = ST_CHK;
               end
            end
         end
         ST_XGO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_XWAIT;
         end
         ST_XWAIT: begin
            if (stat.div_done) begin
               cmd.take_x = 1'b1;
               state_in   = ST_YGO;
            end
         end
         ST_YGO: begin
            cmd.div_go = 1'b1;
            cmd.div_y  = 1'b1;
            state_in   = ST_YWAIT;
         end
         ST_YWAIT: begin
            cmd.div_y = 1'b1;
            if (stat.div_done) begin
               cmd.take_y = 1'b1;
               state_in   = ST_CORR;
            end
         end
         ST_CORR: begin
            cmd.init = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (!stat.walking) begin
               state_in = ST_FIN;
            end else if (stat.y_end) begin
               cmd.stop = 1'b1;
               state_in = ST_FIN;
            end else if (stat.x_end) begin
               cmd.end_row = 1'b1;
            end else if (!stat.second) begin
               state_in = ST_LO;
            end else if (stat.in_map) begin
               state_in = ST_FIN;
            end else begin
               cmd.second_miss = 1'b1;
            end
         end
         ST_LO: begin
            cmd.calc_lo = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            if (stat.lo_bad) begin
               cmd.end_row = 1'b1;
               state_in    = ST_CHK;
            end else begin
               cmd.move = 1'b1;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (stat.in_map) begin
               state_in = ST_FIN;
            end else begin
               cmd.first_miss = 1'b1;
               state_in       = ST_CHK;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ov_in = ov_ff;
      if (cmd.emit) begin
         ov_in = 1'b1;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   assign out_valid = ov_ff;
endmodule

`default_nettype wire

[tb/itw_walk_checker.sv]
// ----------------------------------------------------------------------------
// itw_walk_checker
// Watches the request, response and register ports of the tile walk, keeps
// its own copy of the walk state and compares every draw command it sees.
// ----------------------------------------------------------------------------
`default_nettype none

module itw_walk_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   itw_req_if                                      req_mon,
   itw_rsp_if                                      rsp_mon,
   input  wire logic                               csr_we,
   input  wire logic [itw_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [itw_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                      fail_count,
   output int                                      pending
);
   typedef struct packed {
      logic        draw_enable;
      logic [15:0] draw_tile;
      logic [15:0] draw_px;
      logic [15:0] draw_py;
      logic        overlay_enable;
      logic [7:0]  want_column;
      logic [7:0]  want_row;
      logic        walk_done;
   } draw_cmd_type;

   draw_cmd_type cmd_queue[$];

   longint tile_h, v_left, v_top, v_right, v_bottom, m_cols, m_rows;
   longint col, row, row_col, row_row, px, py, xrem_held;
   bit     second, walking;

   function automatic longint clamp_coord(longint v);
      longint lim;
      lim = (longint'(1) << (itw_pkg::COORD_BITS - 1)) - 1;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint cur_th();
      return (tile_h == 0) ? 1 : tile_h;
   endfunction

   function automatic bit on_map(longint c, longint r);
      return c >= 0 && c < m_cols && r >= 0 && r < m_rows;
   endfunction

   function automatic void next_row();
      longint tw;
      tw = 2 * cur_th();
      py += cur_th();
      row_col = clamp_coord(row_col + 1);
      row_row = clamp_coord(row_row + 1);
      col = row_col;
      row = row_row;
      px = v_left - 2 * tw - xrem_held;
      second = 0;
   endfunction

   // advance to the next in-map cell or finish the walk
   function automatic void seek_cell();
      longint th, tw, xlim, lo, hi, left;
      while (walking) begin
         th = cur_th();
         tw = 2 * th;
         xlim = v_right + 2 * tw;
         if (py >= v_bottom + 2 * th) begin
            walking = 0;
            return;
         end
         if (px >= xlim) begin
            next_row();
            continue;
         end
         if (!second) begin
            lo = 0;
            if (-col - 1 > lo) lo = -col - 1;
            if (row - m_rows + 1 > lo) lo = row - m_rows + 1;
            hi = m_cols - 1 - col;
            if (row < hi) hi = row;
            left = (xlim - px + tw - 1) / tw;
            if (lo > hi || lo >= left) begin
               next_row();
               continue;
            end
            col = clamp_coord(col + lo);
            row = clamp_coord(row - lo);
            px += lo * tw;
            if (on_map(col, row)) return;
            col = clamp_coord(col + 1);
            second = 1;
         end
         if (on_map(col, row)) return;
         row = clamp_coord(row - 1);
         second = 0;
         px += tw;
      end
   endfunction

   function automatic void begin_walk(longint sx, longint sy);
      longint th, tw, halfw, halfh, q, xr, ys, r, yr, c0, r0;
      int sel;
      th = cur_th();
      tw = 2 * th;
      halfw = th;
      halfh = (th + 1) >>> 1;
      q = sx / tw;
      xr = sx % tw;
      ys = sy - halfh;
      r = ys / th;
      yr = ys % th;
      c0 = r + q - 3;
      r0 = r - q;
      sel = (xr >= halfw ? 2 : 1) + (yr > halfh ? 2 : 0);
      // diamond quarter correction
      case (sel)
         1: if (xr < halfw - 2 * yr) begin
            c0--; xr += halfw; yr += halfh;
         end
         2: if (xr >= halfw + 2 * yr) begin
            r0--; xr -= halfw; yr += halfh;
         end
         3: if (xr < halfw + 2 * (yr - th)) begin
            r0++; xr += halfw; yr -= halfh;
         end
         default: if (xr >= halfw + 2 * (th - yr)) begin
            c0++; xr -= halfw; yr -= halfh;
         end
      endcase
      xrem_held = xr;
      col = clamp_coord(c0);
      row = clamp_coord(r0);
      row_col = col;
      row_row = row;
      px = v_left - 2 * tw - xr;
      py = v_top - 2 * th - yr;
      second = 0;
      walking = 1;
      seek_cell();
   endfunction

   function automatic draw_cmd_type predict_draw();
      draw_cmd_type d;
      longint th, dx, dy;
      bit en, ov;
      d = '0;
      en = 0;
      ov = 0;
      dx = 0;
      dy = 0;
      if (req_mon.kind == itw_pkg::KIND_START) begin
         begin_walk(longint'(req_mon.scroll_x), longint'(req_mon.scroll_y));
      end else if (walking) begin
         th = cur_th();
         if (req_mon.tile_id != 0) begin
            if ((req_mon.cell_flag_bits & 16'h3) != 0 && req_mon.cell_flag_bits[3]
                && req_mon.holds_object) begin
               en = !req_mon.object_self_draws;
            end else begin
               en = 1;
               ov = req_mon.path_cell;
            end
         end
         dx = px;
         dy = py;
         if (second) begin
            dx += th;
            dy += (th + 1) >>> 1;
         end
         if (!second) begin
            col = clamp_coord(col + 1);
            if (col == m_cols) next_row();
            else second = 1;
         end else begin
            row = clamp_coord(row - 1);
            second = 0;
            px += 2 * th;
         end
         seek_cell();
      end
      d.draw_enable = en;
      if (en) begin
         d.draw_tile = req_mon.tile_id;
         d.draw_px = dx[15:0];
         d.draw_py = dy[15:0];
         d.overlay_enable = ov;
      end
      if (walking) begin
         d.want_column = col[7:0];
         d.want_row = row[7:0];
      end
      d.walk_done = !walking;
      return d;
   endfunction

   assign pending = cmd_queue.size();

   always @(posedge clock) begin
      draw_cmd_type got, exp_cmd;
      if (reset) begin
         tile_h = 16; v_left = 0; v_top = 0; v_right = 640; v_bottom = 480;
         m_cols = 128; m_rows = 128;
         col = 0; row = 0; row_col = 0; row_row = 0; px = 0; py = 0; xrem_held = 0;
         second = 0;
         walking = 0;
         fail_count = 0;
         cmd_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.draw_enable = rsp_mon.draw_enable;
            got.draw_tile = rsp_mon.draw_tile;
            got.draw_px = rsp_mon.draw_px;
            got.draw_py = rsp_mon.draw_py;
            got.overlay_enable = rsp_mon.overlay_enable;
            got.want_column = rsp_mon.want_column;
            got.want_row = rsp_mon.want_row;
            got.walk_done = rsp_mon.walk_done;
            if (cmd_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected draw item: %p", got);
            end else begin
               exp_cmd = cmd_queue.pop_front();
               if (got !== exp_cmd) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("draw mismatch\n  expected %p\n  actual   %p", exp_cmd, got);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               itw_pkg::REG_TILE_HEIGHT: tile_h = longint'(csr_wdata[7:0]);
               itw_pkg::REG_VIEW_LEFT:   v_left = longint'(csr_wdata);
               itw_pkg::REG_VIEW_TOP:    v_top = longint'(csr_wdata);
               itw_pkg::REG_VIEW_RIGHT:  v_right = longint'(csr_wdata);
               itw_pkg::REG_VIEW_BOTTOM: v_bottom = longint'(csr_wdata);
               itw_pkg::REG_MAP_COLUMNS: m_cols = longint'(csr_wdata[7:0]);
               itw_pkg::REG_MAP_ROWS:    m_rows = longint'(csr_wdata[7:0]);
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) cmd_queue.push_back(predict_draw());
      end
   end

endmodule

`default_nettype wire

[tb/isometric_tile_walk_tb.sv]
// ----------------------------------------------------------------------------
// isometric_tile_walk_tb
// Drives frame starts and cell replies into the tile walk under several
// register settings and idle patterns; the checker judges every draw item.
// ----------------------------------------------------------------------------
`default_nettype none

module isometric_tile_walk_tb;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int PHASES = 12;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [itw_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [itw_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;
   int fail_count, pending, cycles;
   int send_idle_pct, stall_pct;
   int th_set, cols_set, rows_set;

   itw_req_if req_chan ();
   itw_rsp_if rsp_chan ();

   isometric_tile_walk i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   itw_walk_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(logic kind, logic [14:0] sx, logic [14:0] sy,
                            logic [15:0] tile, logic [15:0] flags,
                            logic obj, logic self_draw, logic path);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 0;
         @(negedge clock);
      end
      req_chan.kind = kind;
      req_chan.scroll_x = sx;
      req_chan.scroll_y = sy;
      req_chan.tile_id = tile;
      req_chan.cell_flag_bits = flags;
      req_chan.holds_object = obj;
      req_chan.object_self_draws = self_draw;
      req_chan.path_cell = path;
      req_chan.valid = 1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_start(int sx, int sy);
      send_item(itw_pkg::KIND_START, 15'(sx), 15'(sy), 16'($urandom), 16'($urandom),
                1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic send_reply();
      logic [15:0] flags;
      flags = 16'($urandom);
      if ($urandom_range(1)) flags = {12'($urandom), 1'b1, 1'($urandom), 2'($urandom_range(1, 3))};
      send_item(itw_pkg::KIND_REPLY, 15'($urandom), 15'($urandom),
                ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom), flags,
                1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic write_reg(logic [itw_pkg::CSR_IDX_BITS-1:0] idx, int value);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = itw_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic quiesce();
      req_chan.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_view(int th, int vl, int vt, int vr, int vb, int mc, int mr);
      quiesce();
      write_reg(itw_pkg::REG_TILE_HEIGHT, th);
      write_reg(itw_pkg::REG_VIEW_LEFT, vl);
      write_reg(itw_pkg::REG_VIEW_TOP, vt);
      write_reg(itw_pkg::REG_VIEW_RIGHT, vr);
      write_reg(itw_pkg::REG_VIEW_BOTTOM, vb);
      write_reg(itw_pkg::REG_MAP_COLUMNS, mc);
      write_reg(itw_pkg::REG_MAP_ROWS, mr);
      th_set = (th == 0) ? 1 : th;
      cols_set = mc;
      rows_set = mr;
   endtask

   // a frame: start with a scroll mostly near the map, then a run of cell replies
   task automatic run_frames(int items);
      int sent, n, sx, sy;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(7) == 0) begin
            sx = $urandom_range(32767);
            sy = $urandom_range(32767);
         end else begin
            sx = $urandom_range((cols_set + 2) * 2 * th_set);
            sy = $urandom_range((rows_set + 2) * th_set);
            if (sx > 32767) sx = $urandom_range(32767);
            if (sy > 32767) sy = $urandom_range(32767);
         end
         send_start(sx, sy);
         n = $urandom_range(50);
         repeat (n) begin
            if ($urandom_range(15) == 0) send_start($urandom_range(32767), $urandom_range(32767));
            else send_reply();
         end
         sent += n + 1;
      end
   endtask

   initial begin
      send_idle_pct = 0;
      stall_pct = 0;
      th_set = 16; cols_set = 128; rows_set = 128;
      req_chan.valid = 0;
      req_chan.kind = itw_pkg::KIND_START;
      req_chan.scroll_x = '0;
      req_chan.scroll_y = '0;
      req_chan.tile_id = '0;
      req_chan.cell_flag_bits = '0;
      req_chan.holds_object = 0;
      req_chan.object_self_draws = 0;
      req_chan.path_cell = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reply while idle, scroll extremes, every draw rule, restart
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'hFFFF, 16'hFFFF, 1, 1, 1);
      send_item(itw_pkg::KIND_START, 0, 0, 0, 0, 0, 0, 0);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h0000, 16'h0000, 0, 0, 1);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'hFFFF, 16'h0000, 0, 0, 1);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h1234, 16'h000B, 1, 1, 1);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h4321, 16'h0009, 1, 0, 1);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h0001, 16'h0008, 1, 1, 1);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h8000, 16'h0003, 1, 1, 0);
      send_item(itw_pkg::KIND_START, 15'h7FFF, 15'h7FFF, 0, 0, 0, 0, 0);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h00FF, 16'hFFF7, 1, 1, 1);
      send_item(itw_pkg::KIND_START, 1000, 700, 0, 0, 0, 0, 0);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h0F0F, 16'h0002, 0, 1, 1);
      send_item(itw_pkg::KIND_START, 16, 9, 0, 0, 0, 0, 0);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'hAAAA, 16'h5555, 1, 0, 0);
      load_view(0, 0, 0, 40, 30, 0, 5);
      send_item(itw_pkg::KIND_START, 3, 3, 0, 0, 0, 0, 0);
      send_item(itw_pkg::KIND_REPLY, 0, 0, 16'h0007, 0, 0, 0, 1);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         case (p)
            0: load_view(16, 0, 0, 640, 480, 128, 128);
            1: load_view(1, 0, 0, 64, 48, 255, 255);
            2: load_view(255, 0, 0, 32767, 32767, 255, 255);
            3: load_view(0, 32767, 32767, 32767, 32767, 1, 1);
            4: load_view(8, 100, 50, 300, 200, 1, 255);
            5: load_view(255, 32767, 32767, 0, 0, 255, 1);
            default: begin
               int vl, vt;
               vl = $urandom_range(2000);
               vt = $urandom_range(2000);
               load_view($urandom_range(2, 40), vl, vt, vl + $urandom_range(800),
                         vt + $urandom_range(600), $urandom_range(1, 255),
                         $urandom_range(1, 255));
            end
         endcase
         run_frames(145);
      end

      req_chan.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
